@@ design/ptc_pkg.sv @@
`timescale 1ns / 1ps

package ptc_pkg;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRESSURE_SENSITIVITY   = 3'd0,
    REG_PRESSURE_OFFSET        = 3'd1,
    REG_SENSITIVITY_TEMP_COEFF = 3'd2,
    REG_OFFSET_TEMP_COEFF      = 3'd3,
    REG_REFERENCE_TEMPERATURE  = 3'd4,
    REG_TEMPERATURE_COEFF      = 3'd5
  } cfg_reg_t;

  // 20.00 C is the reference point; -15.00 C lies 3500 hundredths below it.
  localparam logic signed [19:0] TEMP_BASE  = 20'sd2000;
  localparam logic signed [18:0] COLD_SPAN  = 19'sd3500;

  typedef struct packed {
    logic [23:0] raw_pressure_reading;
    logic [23:0] raw_temperature_reading;
  } sample_t;

  typedef struct packed {
    logic signed [18:0] temperature_centi_deg;
    logic signed [31:0] pressure_deci_mbar;
  } result_t;

  // Compensated terms handed to the pressure back end.
  typedef struct packed {
    logic [23:0]        d1;
    logic signed [40:0] sens;
    logic signed [40:0] off;
    logic signed [18:0] temp;
  } press_t;

endpackage

@@ design/ptc_pressure.sv @@
`timescale 1ns / 1ps

module ptc_pressure
  import ptc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    valid,
  input  press_t  terms,
  output logic    done,
  output result_t result
);

  logic signed [19:0] sens_hi;
  logic [20:0]        sens_lo;
  logic signed [44:0] ph_full;
  logic [44:0]        pl_full;

  logic               v7;
  logic signed [44:0] ph;
  logic [23:0]        pl_hi;
  logic signed [40:0] off7;
  logic signed [18:0] temp7;
  logic signed [46:0] q;

  // d1 * sens is split at bit 21 of sens; the low partial product is
  // non-negative, so the floor shift by 21 only keeps its upper bits.
  assign sens_hi = terms.sens[40:21];
  assign sens_lo = terms.sens[20:0];
  assign ph_full = sens_hi * $signed({1'b0, terms.d1});
  assign pl_full = {24'h0, sens_lo} * {21'h0, terms.d1};

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= valid;
    end
    ph    <= ph_full;
    pl_hi <= pl_full[44:21];
    off7  <= terms.off;
    temp7 <= terms.temp;
  end

  assign q = {{2{ph[44]}}, ph} + {23'h0, pl_hi} - {{6{off7[40]}}, off7};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v7;
    end
    result.temperature_centi_deg <= temp7;
    result.pressure_deci_mbar    <= q[44:13];
  end

endmodule

@@ design/pressure_temperature_compensation_unit.sv @@
`timescale 1ns / 1ps

// Second-order compensated temperature and pressure from one pair of raw
// 24-bit readings and six calibration words. The unit is a fixed pipeline:
// it takes a word on every cycle that start is high and busy is low, and the
// result appears in order with a one-cycle done strobe after the word has
// passed all stages. There is no back-pressure, so the result must be
// captured in that cycle. busy is high only while rst is held. Calibration
// registers must be written only when no word is in flight; words in flight
// read them live at several stages.

module pressure_temperature_compensation_unit
  import ptc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  sample_t              sample,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 done,
  output result_t              result
);

  logic [15:0] c_sens, c_off, c_tcs, c_tco, c_tref, c_tsens;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_sens  <= '0;
      c_off   <= '0;
      c_tcs   <= '0;
      c_tco   <= '0;
      c_tref  <= '0;
      c_tsens <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PRESSURE_SENSITIVITY:   c_sens  <= cfg_data;
        REG_PRESSURE_OFFSET:        c_off   <= cfg_data;
        REG_SENSITIVITY_TEMP_COEFF: c_tcs   <= cfg_data;
        REG_OFFSET_TEMP_COEFF:      c_tco   <= cfg_data;
        REG_REFERENCE_TEMPERATURE:  c_tref  <= cfg_data;
        REG_TEMPERATURE_COEFF:      c_tsens <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = rst;

  // Stage 1: temperature difference.
  logic               v1;
  logic [23:0]        d1_s1;
  logic signed [24:0] dt_s1;
  logic signed [24:0] dt_full;

  assign dt_full = $signed({1'b0, sample.raw_temperature_reading})
                 - $signed({1'b0, c_tref, 8'h00});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
    d1_s1 <= sample.raw_pressure_reading;
    dt_s1 <= dt_full;
  end

  // Stage 2: first-order products and the square of dt.
  logic               v2;
  logic [23:0]        d1_s2;
  logic signed [41:0] pt_s2, po_s2, ps_s2;
  logic [47:0]        dsq_s2;
  logic signed [41:0] pt_full, po_full, ps_full;
  logic signed [49:0] dsq_full;

  assign pt_full  = dt_s1 * $signed({1'b0, c_tsens});
  assign po_full  = dt_s1 * $signed({1'b0, c_tco});
  assign ps_full  = dt_s1 * $signed({1'b0, c_tcs});
  assign dsq_full = dt_s1 * dt_s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    d1_s2  <= d1_s1;
    pt_s2  <= pt_full;
    po_s2  <= po_full;
    ps_s2  <= ps_full;
    dsq_s2 <= dsq_full[47:0];
  end

  // Stage 3: first-order offset and sensitivity, region choice and the
  // temperature correction. dlt is the first-order temperature minus 20 C.
  logic               v3;
  logic [23:0]        d1_s3;
  logic signed [18:0] dlt, dlt_s3, v_s3;
  logic signed [34:0] off1, off1_s3;
  logic signed [33:0] sens1, sens1_s3;
  logic [49:0]        dsq_x3;
  logic [16:0]        ti_s3;
  logic               low_s3, cold_s3;

  assign dlt    = pt_s2[41:23];
  assign off1   = $signed({3'b000, c_off, 16'h0000}) + $signed(po_s2[41:7]);
  assign sens1  = $signed({3'b000, c_sens, 15'h0000}) + $signed(ps_s2[41:8]);
  assign dsq_x3 = {2'b00, dsq_s2} + {1'b0, dsq_s2, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    d1_s3    <= d1_s2;
    dlt_s3   <= dlt;
    v_s3     <= dlt + COLD_SPAN;
    off1_s3  <= off1;
    sens1_s3 <= sens1;
    low_s3   <= dlt[18];
    cold_s3  <= dlt < -COLD_SPAN;
    ti_s3    <= dlt[18] ? dsq_x3[49:33] : {5'h00, dsq_s2[47:36]};
  end

  // Stage 4: squares of the temperature deviations and final temperature.
  logic               v4;
  logic [23:0]        d1_s4;
  logic [34:0]        dq_s4, vq_s4;
  logic signed [37:0] dq_full, vq_full;
  logic signed [19:0] temp_full;
  logic signed [18:0] temp_s4;
  logic signed [34:0] off1_s4;
  logic signed [33:0] sens1_s4;
  logic               low_s4, cold_s4;

  assign dq_full   = dlt_s3 * dlt_s3;
  assign vq_full   = v_s3 * v_s3;
  assign temp_full = TEMP_BASE + {dlt_s3[18], dlt_s3} - $signed({3'b000, ti_s3});

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    d1_s4    <= d1_s3;
    dq_s4    <= dq_full[34:0];
    vq_s4    <= vq_full[34:0];
    temp_s4  <= temp_full[18:0];
    off1_s4  <= off1_s3;
    sens1_s4 <= sens1_s3;
    low_s4   <= low_s3;
    cold_s4  <= cold_s3;
  end

  // Stage 5: second-order offset and sensitivity corrections.
  logic               v5;
  logic [23:0]        d1_s5;
  logic [39:0]        dq_x3, dq_x5, vq_x7, vq_x4, offi, sensi;
  logic [39:0]        offi_s5, sensi_s5;
  logic signed [18:0] temp_s5;
  logic signed [34:0] off1_s5;
  logic signed [33:0] sens1_s5;

  assign dq_x3 = {5'h00, dq_s4} + {4'h0, dq_s4, 1'b0};
  assign dq_x5 = {5'h00, dq_s4} + {3'b000, dq_s4, 2'b00};
  assign vq_x7 = {2'b00, vq_s4, 3'b000} - {5'h00, vq_s4};
  assign vq_x4 = {3'b000, vq_s4, 2'b00};

  always_comb begin
    if (low_s4) begin
      offi  = {1'b0, dq_x3[39:1]} + (cold_s4 ? vq_x7 : 40'h0);
      sensi = {3'b000, dq_x5[39:3]} + (cold_s4 ? vq_x4 : 40'h0);
    end else begin
      offi  = {9'h000, dq_s4[34:4]};
      sensi = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    d1_s5    <= d1_s4;
    offi_s5  <= offi;
    sensi_s5 <= sensi;
    temp_s5  <= temp_s4;
    off1_s5  <= off1_s4;
    sens1_s5 <= sens1_s4;
  end

  // Stage 6: corrected offset and sensitivity.
  logic   v6;
  press_t terms_s6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
    terms_s6.d1   <= d1_s5;
    terms_s6.temp <= temp_s5;
    terms_s6.off  <= {{6{off1_s5[34]}}, off1_s5} - $signed({1'b0, offi_s5});
    terms_s6.sens <= {{7{sens1_s5[33]}}, sens1_s5} - $signed({1'b0, sensi_s5});
  end

  ptc_pressure u_pressure (
    .clk    (clk),
    .rst    (rst),
    .valid  (v6),
    .terms  (terms_s6),
    .done   (done),
    .result (result)
  );

endmodule

@@ design/ptc_checker.sv @@
`timescale 1ns / 1ps

module ptc_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  localparam int LATENCY = 8;

  // Every accepted word yields a result after the fixed latency.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted word produced no result");

  // No result appears without a word accepted the same latency earlier.
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without a matching accepted word");

  // Reset flushes the pipeline.
  assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  // The unit never refuses work outside reset.
  assert property (@(posedge clk) !rst |-> !busy)
    else $error("busy outside reset");

endmodule

bind pressure_temperature_compensation_unit ptc_checker u_ptc_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
